/* rtl/segment_lcd_reading_formatter_assert.svh */
// Assertion macros for the segment LCD reading formatter
`ifndef SEGMENT_LCD_READING_FORMATTER_ASSERT_SVH
`define SEGMENT_LCD_READING_FORMATTER_ASSERT_SVH
`ifndef SYNTHESIS
`define SLRF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("slrf assertion failed");
`define SLRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slrf assertion failed");
`else
`define SLRF_ASSERT(label, clk, rst, prop)
`define SLRF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/slrf_pkg.sv */
// Shared types, constants and tables of the segment LCD reading formatter
package slrf_pkg;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       last;
  } byte_t;

  localparam logic [2:0] FN_TEMP  = 3'd0;
  localparam logic [2:0] FN_HUM   = 3'd1;
  localparam logic [2:0] FN_BAT   = 3'd2;
  localparam logic [2:0] FN_LINK  = 3'd3;
  localparam logic [2:0] FN_ERR   = 3'd4;
  localparam logic [2:0] FN_RESET = 3'd5;
  localparam logic [2:0] FN_ON    = 3'd6;
  localparam logic [2:0] FN_OFF   = 3'd7;

  localparam logic [1:0] UNIT_NONE = 2'd0;
  localparam logic [1:0] UNIT_F    = 2'd1;
  localparam logic [1:0] UNIT_C    = 2'd2;

  localparam logic [7:0] SEG_H    = 8'h6e;
  localparam logic [7:0] SEG_I    = 8'h40;
  localparam logic [7:0] SEG_L    = 8'he0;
  localparam logic [7:0] SEG_LO   = 8'hcc;
  localparam logic [7:0] SEG_E    = 8'hf4;
  localparam logic [7:0] SEG_ZERO = 8'hfa;
  localparam logic [7:0] SEG_LINK = 8'h07;
  localparam logic [7:0] SEG_BAT  = 8'hf0;

  localparam logic [7:0] FRAME_HDR   = 8'h0b;
  localparam logic [7:0] BLINK_RESET = 8'hf2;
  localparam logic [7:0] BLINK_HOLD  = 8'hf0;

  localparam logic signed [17:0] HI_LIMIT    = 18'sd19995;
  localparam logic signed [17:0] LO_LIMIT    = -18'sd9995;
  localparam logic signed [17:0] ROUND_LIMIT = 18'sd1999;
  localparam logic signed [17:0] F_OFFSET    = 18'sd320;

  localparam logic [19:0] RECIP10_WIDE = 20'd838861;
  localparam logic [16:0] RECIP10      = 17'd52429;

  localparam int INIT_LEN  = 11;
  localparam int SLEEP_LEN = 3;
  localparam int CMDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 4;

  function automatic logic [7:0] seg_digit(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'hfa;
      4'd1: s = 8'h0a;
      4'd2: s = 8'hd6;
      4'd3: s = 8'h9e;
      4'd4: s = 8'h2e;
      4'd5: s = 8'hbc;
      4'd6: s = 8'hfc;
      4'd7: s = 8'h1a;
      4'd8: s = 8'hfe;
      4'd9: s = 8'hbe;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] init_byte(input logic [3:0] i);
    logic [7:0] b;
    case (i)
      4'd0: b = 8'hea;
      4'd1: b = 8'hc8;
      4'd2: b = 8'hbc;
      4'd3: b = 8'h0c;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] sleep_byte(input logic [3:0] i);
    logic [7:0] b;
    case (i)
      4'd0: b = 8'hea;
      4'd1: b = 8'hbc;
      default: b = 8'hd0;
    endcase
    return b;
  endfunction

  // quotient by ten, exact for every 16-bit input
  function automatic logic [15:0] div10(input logic [15:0] x);
    logic [32:0] p;
    p = {17'b0, x} * {16'b0, RECIP10};
    return {2'b0, p[32:19]};
  endfunction

endpackage

/* rtl/slrf_front.sv */
// Command queue that accepts items ahead of the executor
module slrf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        func,
  input  logic signed [15:0] value,
  output logic              cmd_valid,
  output slrf_pkg::cmd_t    cmd,
  input  logic              cmd_pop
);

  slrf_pkg::cmd_t slot [slrf_pkg::CMDQ_DEPTH];
  logic       head;
  logic       tail;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = count == 2'(slrf_pkg::CMDQ_DEPTH);
  assign cmd_valid = count != 2'd0;
  assign cmd       = slot[head];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        tail <= ~tail;
      end
      if (do_pop) begin
        head <= ~head;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[tail] <= '{func: func, value: value};
    end
  end

endmodule

/* rtl/slrf_back.sv */
// Executor: edits the segment image and sends bus bytes
`include "segment_lcd_reading_formatter_assert.svh"
module slrf_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_data,
  input  logic              cmd_valid,
  input  slrf_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  input  logic              ob_full,
  output logic              ob_push,
  output slrf_pkg::byte_t   ob_item
);

  typedef enum logic [3:0] {
    S_IDLE, S_TF, S_TR, S_TD, S_D0, S_D1, S_D2, S_HW, S_SEQ, S_CMP, S_FR, S_BL
  } state_t;

  state_t state;
  logic [1:0]  temp_unit;
  logic [7:0]  img  [7];
  logic [7:0]  sent [7];
  logic [7:0]  blink;
  logic        display_off;
  logic        seq_on;
  logic [3:0]  idx;
  logic [19:0] mag;
  logic        sign;
  logic        neg;
  logic        rounded;
  logic        is_temp;
  logic [2:0]  sym;
  logic signed [17:0] n;
  logic        fl999, fl99, fl9;
  logic [3:0]  ones, tens;

  logic signed [15:0] v;
  logic signed [20:0] t21;
  logic signed [20:0] t21_neg;
  logic [39:0] fprod;
  logic signed [17:0] fq;
  logic signed [17:0] n_abs;
  logic signed [17:0] n_rnd;
  logic signed [17:0] n_rnd_abs;
  logic [15:0] q;
  logic [15:0] rem;
  logic [7:0]  bat_d0;
  logic [7:0]  frame_byte;
  logic        blink_settled;

  assign v         = cmd.value;
  assign t21       = 21'(v) * 21'sd18 + 21'sd5;
  assign t21_neg   = -t21;
  assign fprod     = {20'b0, mag} * {20'b0, slrf_pkg::RECIP10_WIDE};
  assign fq        = $signed({1'b0, fprod[39:23]});
  assign n_abs     = n[17] ? -n : n;
  assign n_rnd     = n + 18'sd5;
  assign n_rnd_abs = n_rnd[17] ? -n_rnd : n_rnd;
  assign q         = slrf_pkg::div10(mag[15:0]);
  assign rem       = mag[15:0] - ((q << 3) + (q << 1));
  assign cmd_pop   = state == S_IDLE && cmd_valid;
  assign blink_settled = blink == 8'h00 || blink == slrf_pkg::BLINK_HOLD;

  always_comb begin
    bat_d0 = (img[0] & 8'h0f) | 8'h80;
    if (v >= 16'sd25) begin
      bat_d0 = bat_d0 | 8'h20;
    end
    if (v >= 16'sd50) begin
      bat_d0 = bat_d0 | 8'h40;
    end
    if (v >= 16'sd80) begin
      bat_d0 = bat_d0 | 8'h10;
    end
  end

  always_comb begin
    case (idx)
      4'd0: frame_byte = slrf_pkg::FRAME_HDR;
      4'd1: frame_byte = sent[0];
      4'd2: frame_byte = sent[1];
      4'd3: frame_byte = sent[2];
      4'd4: frame_byte = {sent[3][3:0], sent[4][7:4]};
      4'd5: frame_byte = {sent[4][3:0], sent[5][7:4]};
      4'd6: frame_byte = {sent[5][3:0], sent[6][7:4]};
      4'd7: frame_byte = {sent[6][3:0], 4'h0};
      default: frame_byte = 8'h00;
    endcase
  end

  always_comb begin
    ob_push = 1'b0;
    ob_item = '{data: 8'h00, start: 1'b0, last: 1'b0};
    case (state)
      S_SEQ: begin
        ob_push = !ob_full;
        ob_item.data  = seq_on ? slrf_pkg::init_byte(idx) : slrf_pkg::sleep_byte(idx);
        ob_item.start = idx == 4'd0;
        ob_item.last  = !seq_on && idx == 4'(slrf_pkg::SLEEP_LEN - 1);
      end
      S_FR: begin
        ob_push = !ob_full;
        ob_item.data  = frame_byte;
        ob_item.start = idx == 4'd0;
        ob_item.last  = idx == 4'd7 && blink == 8'h00;
      end
      S_BL: begin
        ob_push = !ob_full;
        ob_item.data  = blink;
        ob_item.start = 1'b1;
        ob_item.last  = 1'b1;
      end
      default: begin
        ob_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      temp_unit   <= slrf_pkg::UNIT_F;
      blink       <= 8'h00;
      display_off <= 1'b1;
      idx         <= 4'd0;
      for (int i = 0; i < 7; i++) begin
        img[i]  <= 8'h00;
        sent[i] <= 8'h00;
      end
    end else begin
      if (cfg_valid) begin
        temp_unit <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.func)
              slrf_pkg::FN_TEMP: begin
                is_temp <= 1'b1;
                case (temp_unit)
                  slrf_pkg::UNIT_F: sym <= 3'b011;
                  slrf_pkg::UNIT_C: sym <= 3'b101;
                  default: sym <= 3'b000;
                endcase
                if (temp_unit == slrf_pkg::UNIT_F) begin
                  sign  <= t21[20];
                  mag   <= t21[20] ? t21_neg[19:0] : t21[19:0];
                  state <= S_TF;
                end else begin
                  n     <= 18'(v);
                  state <= S_TR;
                end
              end
              slrf_pkg::FN_HUM: begin
                is_temp <= 1'b0;
                if (v > 16'sd99) begin
                  img[5] <= slrf_pkg::SEG_H;
                  img[6] <= slrf_pkg::SEG_I | 8'h01;
                  state  <= S_CMP;
                end else if (v < -16'sd9) begin
                  img[5] <= slrf_pkg::SEG_L;
                  img[6] <= slrf_pkg::SEG_LO | 8'h01;
                  state  <= S_CMP;
                end else begin
                  neg   <= v[15];
                  mag   <= v[15] ? 20'(-v) : 20'(v);
                  state <= S_D0;
                end
              end
              slrf_pkg::FN_BAT: begin
                img[0] <= bat_d0;
                state  <= S_CMP;
              end
              slrf_pkg::FN_LINK: begin
                img[0] <= (v != 16'sd0) ? (img[0] & ~slrf_pkg::SEG_LINK)
                                        : (img[0] | slrf_pkg::SEG_LINK);
                state  <= S_CMP;
              end
              slrf_pkg::FN_ERR: begin
                img[0] <= img[0] & (slrf_pkg::SEG_BAT | slrf_pkg::SEG_LINK);
                img[1] <= slrf_pkg::SEG_E;
                img[2] <= slrf_pkg::SEG_E;
                img[3] <= 8'h00;
                img[4] <= 8'h00;
                img[5] <= slrf_pkg::SEG_E;
                img[6] <= slrf_pkg::SEG_E;
                state  <= S_CMP;
              end
              slrf_pkg::FN_RESET: begin
                img[0] <= 8'h00;
                img[1] <= slrf_pkg::SEG_LO;
                img[2] <= slrf_pkg::SEG_LO;
                img[3] <= 8'h00;
                img[4] <= 8'h00;
                img[5] <= slrf_pkg::SEG_LO;
                img[6] <= slrf_pkg::SEG_LO;
                blink  <= slrf_pkg::BLINK_RESET;
                state  <= S_CMP;
              end
              slrf_pkg::FN_ON: begin
                display_off <= 1'b0;
                blink       <= 8'h00;
                seq_on      <= 1'b1;
                idx         <= 4'd0;
                state       <= S_SEQ;
              end
              default: begin
                display_off <= 1'b1;
                seq_on      <= 1'b0;
                idx         <= 4'd0;
                state       <= S_SEQ;
              end
            endcase
          end
        end
        S_TF: begin
          n     <= (sign ? -fq : fq) + slrf_pkg::F_OFFSET;
          state <= S_TR;
        end
        S_TR: begin
          img[3] <= {5'b0, sym[2], sym[0], sym[1]};
          img[4] <= 8'h00;
          if (n > slrf_pkg::HI_LIMIT) begin
            img[1] <= slrf_pkg::SEG_H;
            img[2] <= slrf_pkg::SEG_I;
            state  <= S_CMP;
          end else if (n < slrf_pkg::LO_LIMIT) begin
            img[1] <= slrf_pkg::SEG_L;
            img[2] <= slrf_pkg::SEG_LO;
            state  <= S_CMP;
          end else if (n > slrf_pkg::ROUND_LIMIT || n < -slrf_pkg::ROUND_LIMIT) begin
            rounded <= 1'b1;
            sign    <= n_rnd[17];
            mag     <= {2'b0, n_rnd_abs};
            state   <= S_TD;
          end else begin
            rounded <= 1'b0;
            neg     <= n[17];
            mag     <= {2'b0, n_abs};
            state   <= S_D0;
          end
        end
        S_TD: begin
          mag   <= {4'b0, q};
          neg   <= sign && q != 16'd0;
          state <= S_D0;
        end
        S_D0: begin
          fl999 <= mag > 20'd999;
          fl99  <= mag > 20'd99;
          fl9   <= mag > 20'd9;
          ones  <= rem[3:0];
          mag   <= {4'b0, q};
          state <= is_temp ? S_D1 : S_HW;
        end
        S_D1: begin
          tens  <= rem[3:0];
          mag   <= {4'b0, q};
          state <= S_D2;
        end
        S_D2: begin
          img[0] <= {img[0][7:4], fl999, img[0][2:0]};
          img[1] <= (neg ? (fl99 ? 8'h01 : 8'h04) : 8'h00)
                  | (fl99 ? slrf_pkg::seg_digit(rem[3:0]) : 8'h00);
          img[2] <= fl9 ? slrf_pkg::seg_digit(tens) : slrf_pkg::SEG_ZERO;
          img[3] <= {4'b0, !rounded, sym[2], sym[0], sym[1]};
          img[4] <= slrf_pkg::seg_digit(ones);
          state  <= S_CMP;
        end
        S_HW: begin
          img[5] <= fl9 ? slrf_pkg::seg_digit(mag[3:0]) : (neg ? 8'h04 : 8'h00);
          img[6] <= 8'h01 | slrf_pkg::seg_digit(ones);
          state  <= S_CMP;
        end
        S_SEQ: begin
          if (!ob_full) begin
            idx <= idx + 4'd1;
            if (seq_on && idx == 4'(slrf_pkg::INIT_LEN - 1)) begin
              for (int i = 0; i < 7; i++) begin
                img[i]  <= 8'hff;
                sent[i] <= 8'h00;
              end
              state <= S_CMP;
            end else if (!seq_on && idx == 4'(slrf_pkg::SLEEP_LEN - 1)) begin
              state <= S_IDLE;
            end
          end
        end
        S_CMP: begin
          idx <= 4'd0;
          if (display_off || (img == sent)) begin
            state <= S_IDLE;
          end else begin
            for (int i = 0; i < 7; i++) begin
              sent[i] <= img[i];
            end
            state <= S_FR;
          end
        end
        S_FR: begin
          if (!ob_full) begin
            idx <= idx + 4'd1;
            if (idx == 4'd7) begin
              state <= (blink != 8'h00) ? S_BL : S_IDLE;
            end
          end
        end
        S_BL: begin
          if (!ob_full) begin
            blink <= (blink > slrf_pkg::BLINK_HOLD) ? slrf_pkg::BLINK_HOLD : 8'h00;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SLRF_ASSERT(a_frame_only_on, clk, rst, (state == S_FR || state == S_BL) |-> !display_off)
  `SLRF_ASSERT(a_push_has_room, clk, rst, ob_push |-> !ob_full)
  `SLRF_ASSERT_NEXT(a_blink_settles, clk, rst, state == S_BL && !ob_full, blink_settled)
  `SLRF_ASSERT(a_frame_index, clk, rst, state == S_FR |-> idx <= 4'd7)

endmodule

/* rtl/slrf_outq.sv */
// Result queue holding bus bytes until they are popped
module slrf_outq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_push,
  input  slrf_pkg::byte_t in_item,
  output logic            in_full,
  output logic            empty,
  input  logic            pop,
  output slrf_pkg::byte_t item
);

  slrf_pkg::byte_t mem [slrf_pkg::OUTQ_DEPTH];
  logic [1:0] head;
  logic [1:0] tail;
  logic [2:0] count;
  logic       do_push;
  logic       do_pop;

  assign in_full = count == 3'(slrf_pkg::OUTQ_DEPTH);
  assign empty   = count == 3'd0;
  assign item    = mem[head];
  assign do_push = in_push && !in_full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 2'd0;
      tail  <= 2'd0;
      count <= 3'd0;
    end else begin
      if (do_push) begin
        tail <= tail + 2'd1;
      end
      if (do_pop) begin
        head <= head + 2'd1;
      end
      count <= count + 3'(do_push) - 3'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= in_item;
    end
  end

endmodule

/* rtl/segment_lcd_reading_formatter.sv */
// Top level of the segment LCD reading formatter
//
//   channel   handshake           payload
//   command   push / full         func, value
//   bytes     empty / pop         bus_byte, start_transfer, last
//   config    cfg_valid/cfg_ready cfg_data (temp_unit)
//
// A command is dispatched, passes through arithmetic states for temperature
// and humidity readings, then sends its bus bytes.
// Byte output, one per cycle through the result queue while it is not full, sets the rate.
// Reset clears the image copies, sets the display off and the unit to F.
// Two commands queue ahead of the executor; four bytes queue behind it.
module segment_lcd_reading_formatter (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        func,
  input  logic signed [15:0] value,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        bus_byte,
  output logic              start_transfer,
  output logic              last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data
);

  logic            cmd_valid;
  logic            cmd_pop;
  slrf_pkg::cmd_t  cmd;
  logic            ob_full;
  logic            ob_push;
  slrf_pkg::byte_t ob_item;
  slrf_pkg::byte_t item;

  assign cfg_ready      = 1'b1;
  assign bus_byte       = item.data;
  assign start_transfer = item.start;
  assign last           = item.last;

  slrf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .func      (func),
    .value     (value),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  slrf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .ob_full   (ob_full),
    .ob_push   (ob_push),
    .ob_item   (ob_item)
  );

  slrf_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .in_push (ob_push),
    .in_item (ob_item),
    .in_full (ob_full),
    .empty   (empty),
    .pop     (pop),
    .item    (item)
  );

endmodule

/* sim/testbench.sv */
// Testbench for the segment LCD reading formatter: random and directed commands, byte checker
`timescale 1ns / 1ps

module testbench;

  class lcd_scoreboard;
    slrf_pkg::byte_t bytes_q[$];
    int         errors;
    int         mismatches;
    logic [1:0] unit;
    logic [7:0] img[7];
    logic [7:0] sent[7];
    logic [7:0] blink;
    bit         off;
    logic [7:0] seg_tab[10] = '{8'hfa, 8'h0a, 8'hd6, 8'h9e, 8'h2e,
                                8'hbc, 8'hfc, 8'h1a, 8'hfe, 8'hbe};
    slrf_pkg::byte_t burst[$];

    function new();
      unit = slrf_pkg::UNIT_F;
      foreach (img[i]) begin
        img[i] = 8'h00;
        sent[i] = 8'h00;
      end
      blink = 8'h00;
      off = 1'b1;
    endfunction

    function void add(logic [7:0] b, bit st);
      slrf_pkg::byte_t e;
      if (burst.size() >= 19) return;
      e.data = b;
      e.start = st;
      e.last = 1'b0;
      burst.push_back(e);
    endfunction

    function void draw_temp(int n, logic [7:0] flags);
      img[3] = flags;
      img[4] = 8'h00;
      if (n > 19995) begin
        img[1] = slrf_pkg::SEG_H;
        img[2] = slrf_pkg::SEG_I;
      end else if (n < -9995) begin
        img[1] = slrf_pkg::SEG_L;
        img[2] = slrf_pkg::SEG_LO;
      end else begin
        img[1] = 8'h00;
        img[2] = 8'h00;
        if (n > 1999 || n < -1999) n = (n + 5) / 10;
        else img[3] = img[3] | 8'h08;
        if (n < 0) begin
          n = -n;
          img[1] = (n > 99) ? 8'h01 : 8'h04;
        end
        if (n > 999) img[0] = img[0] | 8'h08;
        else img[0] = img[0] & 8'hf7;
        if (n > 99) img[1] = img[1] | seg_tab[(n / 100) % 10];
        if (n > 9) img[2] = img[2] | seg_tab[(n / 10) % 10];
        else img[2] = img[2] | slrf_pkg::SEG_ZERO;
        img[4] = seg_tab[n % 10];
      end
    endfunction

    function void draw_humidity(int n);
      img[5] = 8'h00;
      img[6] = 8'h01;
      if (n > 99) begin
        img[5] = slrf_pkg::SEG_H;
        img[6] = img[6] | slrf_pkg::SEG_I;
      end else if (n < -9) begin
        img[5] = slrf_pkg::SEG_L;
        img[6] = img[6] | slrf_pkg::SEG_LO;
      end else begin
        if (n < 0) begin
          n = -n;
          img[5] = 8'h04;
        end
        if (n > 9) img[5] = seg_tab[(n / 10) % 10];
        img[6] = img[6] | seg_tab[n % 10];
      end
    endfunction

    function void refresh();
      bit same;
      same = 1'b1;
      foreach (img[i]) if (img[i] != sent[i]) same = 1'b0;
      if (off || same) return;
      foreach (img[i]) sent[i] = img[i];
      add(slrf_pkg::FRAME_HDR, 1'b1);
      add(sent[0], 1'b0);
      add(sent[1], 1'b0);
      add(sent[2], 1'b0);
      add({sent[3][3:0], sent[4][7:4]}, 1'b0);
      add({sent[4][3:0], sent[5][7:4]}, 1'b0);
      add({sent[5][3:0], sent[6][7:4]}, 1'b0);
      add({sent[6][3:0], 4'h0}, 1'b0);
      if (blink != 8'h00) begin
        add(blink, 1'b1);
        blink = (blink > slrf_pkg::BLINK_HOLD) ? slrf_pkg::BLINK_HOLD : 8'h00;
      end
    endfunction

    function void note_command(logic [2:0] f, logic signed [15:0] v);
      int n;
      int lvl;
      n = v;
      burst.delete();
      case (f)
        slrf_pkg::FN_TEMP: begin
          if (unit == slrf_pkg::UNIT_F) draw_temp((n * 18 + 5) / 10 + 320, 8'h03);
          else if (unit == slrf_pkg::UNIT_C) draw_temp(n, 8'h06);
          else draw_temp(n, 8'h00);
          refresh();
        end
        slrf_pkg::FN_HUM: begin
          draw_humidity(n);
          refresh();
        end
        slrf_pkg::FN_BAT: begin
          lvl = (n < 0) ? 0 : (n > 100) ? 100 : n;
          img[0] = (img[0] & 8'h0f) | 8'h80;
          if (lvl >= 25) img[0] = img[0] | 8'h20;
          if (lvl >= 50) img[0] = img[0] | 8'h40;
          if (lvl >= 80) img[0] = img[0] | 8'h10;
          refresh();
        end
        slrf_pkg::FN_LINK: begin
          if (n != 0) img[0] = img[0] & ~slrf_pkg::SEG_LINK;
          else img[0] = img[0] | slrf_pkg::SEG_LINK;
          refresh();
        end
        slrf_pkg::FN_ERR: begin
          img[0] = img[0] & (slrf_pkg::SEG_BAT | slrf_pkg::SEG_LINK);
          img[1] = slrf_pkg::SEG_E;
          img[2] = slrf_pkg::SEG_E;
          img[3] = 8'h00;
          img[4] = 8'h00;
          img[5] = slrf_pkg::SEG_E;
          img[6] = slrf_pkg::SEG_E;
          refresh();
        end
        slrf_pkg::FN_RESET: begin
          img[0] = 8'h00;
          img[1] = slrf_pkg::SEG_LO;
          img[2] = slrf_pkg::SEG_LO;
          img[3] = 8'h00;
          img[4] = 8'h00;
          img[5] = slrf_pkg::SEG_LO;
          img[6] = slrf_pkg::SEG_LO;
          blink = slrf_pkg::BLINK_RESET;
          refresh();
        end
        slrf_pkg::FN_ON: begin
          off = 1'b0;
          add(8'hea, 1'b1);
          add(8'hc8, 1'b0);
          add(8'hbc, 1'b0);
          add(8'h0c, 1'b0);
          repeat (7) add(8'h00, 1'b0);
          blink = 8'h00;
          foreach (img[i]) begin
            img[i] = 8'hff;
            sent[i] = 8'h00;
          end
          refresh();
        end
        default: begin
          off = 1'b1;
          add(8'hea, 1'b1);
          add(8'hbc, 1'b0);
          add(8'hd0, 1'b0);
        end
      endcase
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) bytes_q.push_back(burst[i]);
    endfunction

    function void check_byte(slrf_pkg::byte_t got);
      slrf_pkg::byte_t want;
      if (bytes_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10)
          $display("unexpected byte %h start %b last %b", got.data, got.start, got.last);
        return;
      end
      want = bytes_q.pop_front();
      if (got !== want) begin
        errors++;
        if (mismatches++ < 10)
          $display("byte mismatch: expected %h/%b/%b actual %h/%b/%b",
                   want.data, want.start, want.last, got.data, got.start, got.last);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  logic [2:0]        func = slrf_pkg::FN_TEMP;
  logic signed [15:0] value = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [7:0]        bus_byte;
  logic              start_transfer;
  logic              last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_data = slrf_pkg::UNIT_F;

  lcd_scoreboard sb = new();
  bit  no_idle = 1'b0;
  int  hold_cycles = 0;
  int  cycles = 0;

  segment_lcd_reading_formatter dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .func(func), .value(value),
    .empty(empty), .pop(pop), .bus_byte(bus_byte), .start_transfer(start_transfer),
    .last(last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_cmd(logic [2:0] f, logic signed [15:0] v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    func <= f;
    value <= v;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_command(f, v);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.bytes_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_unit(logic [1:0] u);
    drain();
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= u;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.unit = u;
  endtask

  function automatic logic signed [15:0] pick_value(logic [2:0] f);
    case ($urandom_range(0, 5))
      0, 1: return 16'($urandom());
      2: return 16'($urandom_range(0, 2000) - 1000);
      3: return 16'($urandom_range(0, 150) - 20);
      4: return 16'($urandom_range(0, 1200) + 18800 - (f == slrf_pkg::FN_TEMP ? 0 : 30000));
      default: return 16'($urandom_range(0, 300) - 10150
                          + (f == slrf_pkg::FN_TEMP ? 0 : 12000));
    endcase
  endfunction

  task automatic random_phase(int count);
    logic [2:0] f;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 19))
        0: f = slrf_pkg::FN_ON;
        1: f = slrf_pkg::FN_OFF;
        2: f = slrf_pkg::FN_ERR;
        3: f = slrf_pkg::FN_RESET;
        4, 5: f = slrf_pkg::FN_LINK;
        6, 7, 8: f = slrf_pkg::FN_BAT;
        9, 10, 11, 12: f = slrf_pkg::FN_HUM;
        default: f = slrf_pkg::FN_TEMP;
      endcase
      if (sb.off && $urandom_range(0, 2) == 0) f = slrf_pkg::FN_ON;
      send_cmd(f, f == slrf_pkg::FN_LINK && $urandom_range(0, 1) ? 16'sd0 : pick_value(f));
    end
    no_idle = 1'b0;
  endtask

  // receiver
  initial begin
    slrf_pkg::byte_t got;
    int w;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      w = no_idle ? 0 : $urandom_range(0, 14);
      if (w > 0) begin
        pop <= 1'b0;
        repeat (w) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      got.data = bus_byte;
      got.start = start_transfer;
      got.last = last;
      sb.check_byte(got);
    end
  end

  initial begin
    logic signed [15:0] temps[14];
    temps = '{16'sd32767, -16'sd32768, 16'sd19995, 16'sd19996,
      -16'sd9995, -16'sd9996, 16'sd1999, 16'sd2000, -16'sd1999, -16'sd2000,
      16'sd19991, 16'sd0, -16'sd5, 16'sd995};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_cmd(slrf_pkg::FN_TEMP, 16'sd250);
    send_cmd(slrf_pkg::FN_ON, 16'sd0);
    foreach (temps[i]) send_cmd(slrf_pkg::FN_TEMP, temps[i]);
    send_cmd(slrf_pkg::FN_HUM, 16'sd100);
    send_cmd(slrf_pkg::FN_HUM, -16'sd10);
    send_cmd(slrf_pkg::FN_HUM, -16'sd9);
    send_cmd(slrf_pkg::FN_BAT, -16'sd5);
    send_cmd(slrf_pkg::FN_BAT, 16'sd60);
    send_cmd(slrf_pkg::FN_BAT, 16'sd200);
    send_cmd(slrf_pkg::FN_LINK, 16'sd1);
    send_cmd(slrf_pkg::FN_LINK, 16'sd0);
    send_cmd(slrf_pkg::FN_ERR, 16'sd0);
    send_cmd(slrf_pkg::FN_RESET, 16'sd0);
    send_cmd(slrf_pkg::FN_HUM, 16'sd42);
    send_cmd(slrf_pkg::FN_OFF, 16'sd0);

    write_unit(slrf_pkg::UNIT_C);
    send_cmd(slrf_pkg::FN_ON, 16'sd0);
    hold_cycles = 400;
    no_idle = 1'b1;
    for (int i = 0; i < 12; i++) send_cmd(slrf_pkg::FN_TEMP, 16'($urandom_range(0, 600)));
    no_idle = 1'b0;
    drain();
    random_phase(100);
    write_unit(slrf_pkg::UNIT_NONE);
    random_phase(100);
    write_unit(2'd3);
    random_phase(100);
    write_unit(slrf_pkg::UNIT_F);
    random_phase(110);

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.bytes_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
